@@ src/tot_pkg.sv @@
// Shared types and constants for the trapezoid opacity transfer block.
// Used by every module of the block; depends on nothing else.
package tot_pkg;

	localparam int OP_BITS  = 16;
	localparam int NUM_AXES = 3;

	localparam logic [47:0]        SHAPE_RESET = 48'h8000_8000_3000;
	localparam logic [OP_BITS-1:0] PEAK_RESET  = 16'hFFFF;
	localparam logic [1:0]         DIMS_RESET  = 2'd1;
	localparam logic [1:0]         DIMS_ONE    = 2'd1;
	localparam logic [1:0]         DIMS_ALL    = 2'd3;

	typedef enum logic [2:0] {
		REG_AXIS_X = 3'd0,
		REG_AXIS_Y = 3'd1,
		REG_AXIS_Z = 3'd2,
		REG_PEAK   = 3'd3,
		REG_DIMS   = 3'd4
	} cfg_reg_t;

	// Per-axis classification of one sample.
	typedef struct packed {
		logic outer;
		logic inner;
		logic below;
	} axis_flags_t;

endpackage

@@ src/tot_front.sv @@
// Front end: bound compare, flank selection and the peak-times-numerator product.
// Three pipeline stages; uses tot_pkg and feeds tot_div.
module tot_front import tot_pkg::*; #(
	parameter int CB = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [CB-1:0]       x_coord,
	input  logic [CB-1:0]       y_coord,
	input  logic [CB-1:0]       z_coord,
	input  logic [3*CB-1:0]     axis_shape [NUM_AXES],
	input  logic [OP_BITS-1:0]  peak,
	input  logic [1:0]          tf_dims,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [OP_BITS+CB-1:0] prod,
	output logic [CB-1:0]       den
);

	localparam int SW = CB + 3;
	localparam int PW = OP_BITS + CB;

	logic [CB-1:0]        coord [NUM_AXES];
	logic [CB-1:0]        fc [NUM_AXES];
	logic [CB-1:0]        fb [NUM_AXES];
	logic [CB-1:0]        ft [NUM_AXES];
	logic signed [SW-1:0] p2 [NUM_AXES];
	logic signed [SW-1:0] c2 [NUM_AXES];
	logic signed [SW-1:0] lo_out [NUM_AXES];
	logic signed [SW-1:0] hi_out [NUM_AXES];
	logic signed [SW-1:0] lo_in [NUM_AXES];
	logic signed [SW-1:0] hi_in [NUM_AXES];
	logic signed [SW-1:0] rise_w [NUM_AXES];
	logic signed [SW-1:0] fall_w [NUM_AXES];
	axis_flags_t          flags_n [NUM_AXES];

	axis_flags_t          flags_s1 [NUM_AXES];
	logic [CB-1:0]        rise_s1 [NUM_AXES];
	logic [CB-1:0]        fall_s1 [NUM_AXES];
	logic                 vld_s1;

	logic [1:0]           dims_e;
	logic                 outside;
	logic                 plateau;
	logic [1:0]           sel;
	logic signed [CB:0]   den_raw;
	logic [CB-1:0]        num_n;
	logic [CB-1:0]        den_n;

	logic [CB-1:0]        num_s2;
	logic [CB-1:0]        den_s2;
	logic                 vld_s2;

	logic [PW-1:0]        prod_s3;
	logic [CB-1:0]        den_s3;
	logic                 vld_s3;

	logic                 adv1;
	logic                 adv2;
	logic                 adv3;

	// A stage takes a new beat when it is empty or its content moves on.
	assign adv3     = !vld_s3 || !out_stall;
	assign adv2     = !vld_s2 || adv3;
	assign adv1     = !vld_s1 || adv2;
	assign in_stall = !adv1;

	assign coord[0] = x_coord;
	assign coord[1] = y_coord;
	assign coord[2] = z_coord;

	// Stage 1: all bounds at doubled scale so the halved widths stay exact.
	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			fc[i]     = axis_shape[i][3*CB-1:2*CB];
			fb[i]     = axis_shape[i][2*CB-1:CB];
			ft[i]     = axis_shape[i][CB-1:0];
			p2[i]     = $signed({2'b00, coord[i], 1'b0});
			c2[i]     = $signed({2'b00, fc[i], 1'b0});
			lo_out[i] = c2[i] - $signed({3'b000, fb[i]});
			hi_out[i] = c2[i] + $signed({3'b000, fb[i]});
			lo_in[i]  = c2[i] - $signed({3'b000, ft[i]});
			hi_in[i]  = c2[i] + $signed({3'b000, ft[i]});
			rise_w[i] = p2[i] - lo_out[i];
			fall_w[i] = hi_out[i] - p2[i];
			flags_n[i].outer = (p2[i] >= lo_out[i]) && (p2[i] <= hi_out[i]);
			flags_n[i].inner = (p2[i] >= lo_in[i]) && (p2[i] <= hi_in[i]);
			flags_n[i].below = p2[i] < lo_in[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= in_valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				flags_s1[i] <= flags_n[i];
				rise_s1[i]  <= rise_w[i][CB-1:0];
				fall_s1[i]  <= fall_w[i][CB-1:0];
			end
		end
	end

	// Stage 2: reduce the flags to one division job. Every outcome is a
	// quotient: zero is 0/1, the peak is peak*1/1.
	always_comb begin
		dims_e  = (tf_dims == 2'd0) ? DIMS_ONE : tf_dims;
		outside = 1'b0;
		plateau = 1'b1;
		for (int i = 0; i < NUM_AXES; i++) begin
			if (2'(i) < dims_e) begin
				if (!flags_s1[i].outer) outside = 1'b1;
				if (!flags_s1[i].inner) plateau = 1'b0;
			end
		end
		// With fewer than three axes the flank axis is x unless x is inside.
		sel     = {1'b0, flags_s1[0].inner};
		den_raw = $signed({1'b0, fb[sel]}) - $signed({1'b0, ft[sel]});
		priority if (outside) begin
			num_n = '0;
			den_n = CB'(1);
		end else if (plateau) begin
			num_n = CB'(1);
			den_n = CB'(1);
		end else if (dims_e == DIMS_ALL) begin
			num_n = '0;
			den_n = CB'(1);
		end else if (den_raw <= 0) begin
			num_n = CB'(1);
			den_n = CB'(1);
		end else begin
			num_n = flags_s1[sel].below ? rise_s1[sel] : fall_s1[sel];
			den_n = den_raw[CB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			num_s2 <= num_n;
			den_s2 <= den_n;
		end
		if (adv3) begin
			prod_s3 <= PW'(peak) * PW'(num_s2);
			den_s3  <= den_s2;
		end
	end

	assign out_valid = vld_s3;
	assign prod      = prod_s3;
	assign den       = den_s3;

endmodule

@@ src/tot_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, for the flank ramp.
// Uses tot_pkg; fed by tot_front.
module tot_div import tot_pkg::*; #(
	parameter int CB = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [OP_BITS+CB-1:0] prod,
	input  logic [CB-1:0]         den,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [OP_BITS-1:0]    quo
);

	localparam int NS = OP_BITS;
	localparam int NW = OP_BITS + CB;

	logic [NW-1:0]      rem_s [NS];
	logic [CB-1:0]      den_s [NS];
	logic [OP_BITS-1:0] quo_s [NS];
	logic               vld_s [NS];

	logic [NW-1:0]      rem_in [NS];
	logic [CB-1:0]      den_in [NS];
	logic [OP_BITS-1:0] quo_in [NS];
	logic               vld_in [NS];
	logic               adv [NS];

	// The quotient never exceeds the peak, so 16 bits of it suffice.
	for (genvar j = 0; j < NS; j++) begin : g_stage
		localparam int K = NS - 1 - j;

		logic [NW-1:0] trial;
		logic          ge;

		if (j == 0) begin : g_first
			assign rem_in[j] = prod;
			assign den_in[j] = den;
			assign quo_in[j] = '0;
			assign vld_in[j] = in_valid;
		end else begin : g_next
			assign rem_in[j] = rem_s[j-1];
			assign den_in[j] = den_s[j-1];
			assign quo_in[j] = quo_s[j-1];
			assign vld_in[j] = vld_s[j-1];
		end

		if (j == NS - 1) begin : g_last_adv
			assign adv[j] = !vld_s[j] || !out_stall;
		end else begin : g_mid_adv
			assign adv[j] = !vld_s[j] || adv[j+1];
		end

		assign trial = NW'(den_in[j]) << K;
		assign ge    = rem_in[j] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (adv[j]) begin
				vld_s[j] <= vld_in[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv[j]) begin
				rem_s[j] <= ge ? (rem_in[j] - trial) : rem_in[j];
				den_s[j] <= den_in[j];
				quo_s[j] <= quo_in[j] | (ge ? (OP_BITS'(1) << K) : '0);
			end
		end
	end

	assign in_stall  = !adv[0];
	assign out_valid = vld_s[NS-1];
	assign quo       = quo_s[NS-1];

endmodule

@@ src/trapezoid_opacity_transfer.sv @@
// Trapezoid opacity transfer function: sample coordinate in, opacity out.
// Top level; uses tot_pkg, tot_front and tot_div.
//
// Usage: a sample beat (x_coord, y_coord, z_coord) is taken at a rising edge
// with in_valid high and in_stall low; the opacity beat leaves on out_valid
// and is taken when out_stall is low. Configuration is a plain write port:
// cfg_we, cfg_index (0 to 4, larger indexes are ignored) and cfg_data.
// Write configuration only while no beat is in flight.
// Pipeline: 19 stages, three for bound compare, flank selection and
// the peak product, then 16 divider stages that each settle one quotient bit.
// Throughput: one sample per cycle while in_stall is low. Each stage holds a beat with its own
// valid bit, so empty stages fill up while the output is stalled; in_stall
// rises only once every stage holds a beat and out_stall is high.
// Reset clears all valid bits and sets each axis to center 0.5, bottom
// width 0.5, top width 0.1875, peak opacity to full and one axis in use.
module trapezoid_opacity_transfer import tot_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [2:0]              cfg_index,
	input  logic [3*COORD_BITS-1:0] cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [COORD_BITS-1:0]   x_coord,
	input  logic [COORD_BITS-1:0]   y_coord,
	input  logic [COORD_BITS-1:0]   z_coord,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [OP_BITS-1:0]      opacity
);

	localparam int SHAPE_BITS = 3 * COORD_BITS;
	// Center 0.5, bottom width 0.5 and top width 0.1875 at any coordinate width.
	localparam logic [SHAPE_BITS-1:0] ShapeReset = {
		COORD_BITS'(1) << (COORD_BITS - 1),
		COORD_BITS'(1) << (COORD_BITS - 1),
		COORD_BITS'(3) << (COORD_BITS - 4)
	};

	logic [SHAPE_BITS-1:0]        axis_q [NUM_AXES];
	logic [OP_BITS-1:0]           peak_q;
	logic [1:0]                   dims_q;

	logic                         div_valid;
	logic                         div_stall;
	logic [OP_BITS+COORD_BITS-1:0] div_prod;
	logic [COORD_BITS-1:0]        div_den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) axis_q[i] <= ShapeReset;
			peak_q <= PEAK_RESET;
			dims_q <= DIMS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_AXIS_X: axis_q[0] <= cfg_data;
				REG_AXIS_Y: axis_q[1] <= cfg_data;
				REG_AXIS_Z: axis_q[2] <= cfg_data;
				REG_PEAK:   peak_q    <= cfg_data[OP_BITS-1:0];
				REG_DIMS:   dims_q    <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	tot_front #(.CB(COORD_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.x_coord    (x_coord),
		.y_coord    (y_coord),
		.z_coord    (z_coord),
		.axis_shape (axis_q),
		.peak       (peak_q),
		.tf_dims    (dims_q),
		.out_valid  (div_valid),
		.out_stall  (div_stall),
		.prod       (div_prod),
		.den        (div_den)
	);

	tot_div #(.CB(COORD_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.in_stall  (div_stall),
		.prod      (div_prod),
		.den       (div_den),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.quo       (opacity)
	);

	// The ramp is a fraction of the peak, so no result may exceed it.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> opacity <= peak_q)
		else $error("opacity above peak opacity");

	// Back pressure may only reach the divider input when the output is stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_stall |-> (out_valid && out_stall))
		else $error("divider stalled with a free output");

	// The input is stalled only when the whole pipeline is blocked.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (div_stall && out_valid && out_stall))
		else $error("input stalled with room in the pipeline");

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for trapezoid_opacity_transfer: drives sample beats,
// predicts each opacity from a shadow copy of the shape registers, compares in order.
// Depends on tot_pkg and the RTL of the block; nothing else.
module testbench;
	import tot_pkg::*;

	localparam int COORD_BITS  = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_TAIL  = 40;

	typedef struct {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] z;
		logic [OP_BITS-1:0]    opacity;
	} sample_rec_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [2:0]              cfg_index = '0;
	logic [3*COORD_BITS-1:0] cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [COORD_BITS-1:0]   x_coord = '0;
	logic [COORD_BITS-1:0]   y_coord = '0;
	logic [COORD_BITS-1:0]   z_coord = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [OP_BITS-1:0]      opacity;

	// Shadow copy of the configuration registers.
	logic [47:0]        axis_shape [3] = '{SHAPE_RESET, SHAPE_RESET, SHAPE_RESET};
	logic [OP_BITS-1:0] peak_reg = PEAK_RESET;
	logic [1:0]         dims_reg = DIMS_RESET;

	sample_rec_t pending_opacity [$];
	int failures = 0;
	int cycle_count = 0;
	bit stall_enable = 1'b1;
	int hold_request = 0;

	trapezoid_opacity_transfer #(.COORD_BITS(COORD_BITS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.x_coord   (x_coord),
		.y_coord   (y_coord),
		.z_coord   (z_coord),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.opacity   (opacity)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic [OP_BITS-1:0] expected_opacity(logic [COORD_BITS-1:0] x,
			logic [COORD_BITS-1:0] y, logic [COORD_BITS-1:0] z);
		longint pos [3];
		longint lo_out [3];
		longint hi_out [3];
		longint lo_in [3];
		longint hi_in [3];
		longint c2, b, t, num, den, peak, quotient;
		int axes, flank_axis;
		pos[0] = x;
		pos[1] = y;
		pos[2] = z;
		peak = peak_reg;
		axes = (dims_reg == '0) ? 1 : int'(dims_reg);
		flank_axis = -1;
		// All bounds live at doubled scale so that half widths stay exact.
		for (int k = 0; k < 3; k++) begin
			c2 = axis_shape[k][47:32];
			b = axis_shape[k][31:16];
			t = axis_shape[k][15:0];
			c2 = 2 * c2;
			pos[k] = 2 * pos[k];
			lo_out[k] = c2 - b;
			hi_out[k] = c2 + b;
			lo_in[k] = c2 - t;
			hi_in[k] = c2 + t;
		end
		for (int k = 0; k < axes; k++)
			if (pos[k] < lo_out[k] || pos[k] > hi_out[k])
				return '0;
		for (int k = axes - 1; k >= 0; k--)
			if (pos[k] < lo_in[k] || pos[k] > hi_in[k])
				flank_axis = k;
		if (flank_axis < 0)
			return peak_reg;
		// A flank with three axes in use is not interpolated.
		if (axes == int'(DIMS_ALL))
			return '0;
		if (pos[flank_axis] < lo_in[flank_axis]) begin
			num = pos[flank_axis] - lo_out[flank_axis];
			den = lo_in[flank_axis] - lo_out[flank_axis];
		end else begin
			num = hi_out[flank_axis] - pos[flank_axis];
			den = hi_out[flank_axis] - hi_in[flank_axis];
		end
		if (den <= 0)
			return peak_reg;
		if (num < 0)
			num = 0;
		if (num > den)
			num = den;
		quotient = peak * num / den;
		return (quotient > peak) ? peak_reg : OP_BITS'(quotient);
	endfunction

	// Mostly lands inside the outer box of the axis, sometimes on or next to a bound, sometimes anywhere.
	function automatic logic [COORD_BITS-1:0] pick_coord(int k);
		longint c2, b, t, lo, hi, p;
		c2 = axis_shape[k][47:32];
		b = axis_shape[k][31:16];
		t = axis_shape[k][15:0];
		c2 = 2 * c2;
		case ($urandom_range(0, 9))
			0, 1: p = $urandom_range(0, 65535);
			2: begin
				case ($urandom_range(0, 3))
					0: p = c2 - b;
					1: p = c2 - t;
					2: p = c2 + t;
					default: p = c2 + b;
				endcase
				p = p / 2 + longint'($urandom_range(0, 2)) - 1;
			end
			default: begin
				lo = (c2 - b) / 2;
				hi = (c2 + b) / 2;
				if (lo < 0)
					lo = 0;
				if (hi > 65535)
					hi = 65535;
				p = lo + longint'($urandom_range(0, int'(hi - lo)));
			end
		endcase
		if (p < 0)
			p = 0;
		if (p > 65535)
			p = 65535;
		return COORD_BITS'(p);
	endfunction

	function automatic logic [47:0] random_shape();
		logic [15:0] c, b, t;
		c = 16'($urandom());
		b = 16'($urandom());
		case ($urandom_range(0, 7))
			0: t = b;
			1: t = 16'($urandom_range(b, 65535));
			default: t = 16'($urandom_range(0, b));
		endcase
		return {c, b, t};
	endfunction

	task automatic note_failure(input string msg);
		failures++;
		if (failures <= 10)
			$display("%s", msg);
	endtask

	always @(posedge clk) begin : check_opacity
		sample_rec_t head;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_opacity.size() == 0) begin
				note_failure($sformatf("opacity beat %h arrived with nothing pending", opacity));
			end else begin
				head = pending_opacity.pop_front();
				if (opacity !== head.opacity)
					note_failure($sformatf("x=%h y=%h z=%h: expected opacity %h, got %h",
						head.x, head.y, head.z, head.opacity, opacity));
			end
		end
	end

	// The receiver stalls in runs of its own unless stalls are disabled; a hold request overrides both.
	initial begin : receiver
		bit holding_back;
		int run_left;
		int hold_left;
		holding_back = 1'b0;
		run_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (!stall_enable) begin
				out_stall <= 1'b0;
			end else begin
				if (run_left == 0) begin
					holding_back = !holding_back;
					run_left = holding_back ? $urandom_range(1, 6) : $urandom_range(1, 12);
				end
				run_left--;
				out_stall <= holding_back;
			end
		end
	end

	// Called at a clock edge; returns at the edge that takes the beat.
	task automatic send_sample(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
			input logic [COORD_BITS-1:0] z);
		sample_rec_t rec;
		in_valid <= 1'b1;
		x_coord <= x;
		y_coord <= y;
		z_coord <= z;
		do
			@(posedge clk);
		while (in_stall);
		rec.x = x;
		rec.y = y;
		rec.z = z;
		rec.opacity = expected_opacity(x, y, z);
		pending_opacity.insert(pending_opacity.size(), rec);
	endtask

	task automatic pause_sender(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (pending_opacity.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] reg_index, input logic [47:0] value);
		cfg_we <= 1'b1;
		cfg_index <= reg_index;
		cfg_data <= value;
		@(posedge clk);
		case (reg_index)
			REG_AXIS_X: axis_shape[0] = value;
			REG_AXIS_Y: axis_shape[1] = value;
			REG_AXIS_Z: axis_shape[2] = value;
			REG_PEAK: peak_reg = value[OP_BITS-1:0];
			REG_DIMS: dims_reg = value[1:0];
			default: ;
		endcase
	endtask

	// Bits above each narrow field carry noise, which the block must ignore.
	task automatic configure(input logic [47:0] sx, input logic [47:0] sy, input logic [47:0] sz,
			input logic [OP_BITS-1:0] peak, input logic [1:0] dims, input bit stray_writes);
		wait_drain();
		write_reg(REG_AXIS_X, sx);
		write_reg(REG_AXIS_Y, sy);
		write_reg(REG_AXIS_Z, sz);
		write_reg(REG_PEAK, {$urandom(), peak});
		write_reg(REG_DIMS, {$urandom(), 14'($urandom()), dims});
		if (stray_writes)
			for (int i = REG_DIMS + 1; i < 8; i++)
				write_reg(3'(i), {$urandom(), 16'($urandom())});
		cfg_we <= 1'b0;
	endtask

	task automatic send_batch(input int count);
		int burst, gap;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 24);
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				if (gap > 0)
					pause_sender(gap);
			end
			send_sample(pick_coord(0), pick_coord(1), pick_coord(2));
			burst--;
		end
	endtask

	task automatic test_default_shape();
		logic [COORD_BITS-1:0] sweep [] = '{16'h0000, 16'h4000, 16'h5000, 16'h6800, 16'h8000,
			16'h9800, 16'hA000, 16'hC000, 16'hFFFF};
		foreach (sweep[i])
			send_sample(sweep[i], 16'($urandom()), 16'($urandom()));
	endtask

	task automatic test_special_cases();
		// A zero dimension count behaves as one axis; stray indexes change nothing.
		configure({16'h4000, 16'h4000, 16'h1000}, SHAPE_RESET, SHAPE_RESET, 16'hFFFF, 2'd0, 1'b1);
		send_sample(16'h0000, 16'($urandom()), 16'($urandom()));
		send_sample(16'h3000, 16'($urandom()), 16'($urandom()));
		send_sample(16'h5800, 16'($urandom()), 16'($urandom()));

		// Two axes: the first axis off its plateau picks the flank.
		configure({16'h4000, 16'h4000, 16'h1000}, {16'h8000, 16'h4000, 16'h2000}, SHAPE_RESET,
			16'hC000, 2'd2, 1'b0);
		send_sample(16'h4000, 16'h6C00, 16'($urandom()));
		send_sample(16'h3000, 16'h6C00, 16'($urandom()));
		send_sample(16'h4000, 16'h5FFF, 16'($urandom()));
		send_sample(16'h4000, 16'h8000, 16'($urandom()));

		// Three axes: any flank gives zero.
		configure({16'h4000, 16'h4000, 16'h1000}, {16'h8000, 16'h4000, 16'h2000},
			{16'h8000, 16'h2000, 16'h1000}, 16'h9ABC, DIMS_ALL, 1'b0);
		send_sample(16'h4000, 16'h8000, 16'h8000);
		send_sample(16'h4000, 16'h8000, 16'h7400);
		send_sample(16'h3000, 16'h8000, 16'h8000);
		send_sample(16'h4000, 16'h8000, 16'hFFFF);

		// Top wider than bottom: the plateau fills the outer box.
		configure({16'h8000, 16'h1000, 16'h4000}, SHAPE_RESET, SHAPE_RESET, 16'hFFFF, DIMS_ONE,
			1'b0);
		send_sample(16'h8800, 16'($urandom()), 16'($urandom()));
		send_sample(16'h8801, 16'($urandom()), 16'($urandom()));

		// Equal widths leave a flank of zero width.
		configure({16'h8000, 16'h2000, 16'h2000}, SHAPE_RESET, SHAPE_RESET, 16'hFFFF, DIMS_ONE,
			1'b0);
		send_sample(16'h7000, 16'($urandom()), 16'($urandom()));
		send_sample(16'h6FFF, 16'($urandom()), 16'($urandom()));

		configure(SHAPE_RESET, SHAPE_RESET, SHAPE_RESET, 16'h0000, DIMS_ONE, 1'b0);
		send_sample(16'h8000, 16'($urandom()), 16'($urandom()));
	endtask

	task automatic test_random_shapes();
		logic [OP_BITS-1:0] peak;
		for (int phase = 0; phase < 14; phase++) begin
			case ($urandom_range(0, 3))
				0: peak = '0;
				1: peak = '1;
				default: peak = OP_BITS'($urandom());
			endcase
			if (phase == 0)
				configure('0, '0, '0, PEAK_RESET, DIMS_ALL, 1'b0);
			else if (phase == 1)
				configure('1, '1, '1, '0, 2'd2, 1'b0);
			else
				configure(random_shape(), random_shape(), random_shape(), peak, 2'(phase),
					$urandom_range(0, 3) == 0);
			stall_enable = ($urandom_range(0, 3) != 0);
			send_batch(100);
		end
	endtask

	task automatic test_backpressure();
		configure(random_shape(), random_shape(), SHAPE_RESET, OP_BITS'($urandom()), 2'd2, 1'b0);
		stall_enable = 1'b1;
		// A long hold while beats keep coming fills every stage and stalls the input.
		hold_request = 400;
		for (int i = 0; i < 90; i++)
			send_sample(pick_coord(0), pick_coord(1), pick_coord(2));
		wait_drain();
		send_batch(30);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_default_shape();
		test_special_cases();
		test_random_shapes();
		test_backpressure();
		wait_drain();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ trapezoid_opacity_transfer.f @@
src/tot_pkg.sv
src/tot_front.sv
src/tot_div.sv
src/trapezoid_opacity_transfer.sv
test/testbench.sv
